// ===== rtl/core/sdaf_pkg.sv =====
`default_nettype none

package sdaf_pkg;

    // Default width of the signed input value.
    localparam int DEF_VALUE_BITS = 32;

    // Shift-and-add-3 iterations done in each conversion stage.
    localparam int ITERS_PER_STAGE = 4;

    // ASCII codes that the formatter emits.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Decimal digits needed for a magnitude of up to 2**(w-1).
    // 1233/4096 is just below log10(2), but the product uses w rather than w-1, so this does not run short.
    function automatic int num_digits(input int w);
        return ((w * 1233) >> 12) + 1;
    endfunction

    // Register stages used by the binary to BCD conversion.
    function automatic int conv_stages(input int w);
        return (w + ITERS_PER_STAGE - 1) / ITERS_PER_STAGE;
    endfunction

endpackage : sdaf_pkg

`default_nettype wire

// ===== rtl/core/signed_decimal_ascii_formatter_unit.sv =====
`default_nettype none

// Signed decimal formatter: each input beat carries one two's complement integer, and the
// block answers with its decimal text as a run of ASCII output beats, most significant digit
// first, a '-' first for a negative value, '0' alone for zero, the final beat flagged by
// o_last_char. The most negative value is printed in full. An input beat passes an input
// stage, ceil(VALUE_BITS/4) conversion stages (four shift-and-add-3 steps each), a leading
// zero search stage, the character serializer and the output register before its first
// character appears. A new value can enter every cycle while o_stall is low, and the
// serializer sends one character per cycle while i_stall is low, so the sustained rate is set
// by the output: each value gives 1 to 11 characters at 32 bits, and the text of a value
// that is already waiting follows the previous text without a gap.
module signed_decimal_ascii_formatter_unit #(
    parameter int VALUE_BITS = sdaf_pkg::DEF_VALUE_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [7:0]                        o_text_char,
    output logic                              o_last_char
);
    import sdaf_pkg::*;

    localparam int NUM_DIG = num_digits(VALUE_BITS);
    localparam int BCD_W   = 4 * NUM_DIG;
    localparam int IDX_W   = $clog2(NUM_DIG);
    localparam int NCONV   = conv_stages(VALUE_BITS);

    typedef logic [BCD_W-1:0]      t_bcd;
    typedef logic [VALUE_BITS-1:0] t_mag;

    // Stage 0 captures sign and magnitude, stages 1..NCONV convert to BCD.
    logic r_vld [0:NCONV];
    logic r_neg [0:NCONV];
    t_bcd r_bcd [0:NCONV];
    t_mag r_bin [0:NCONV];
    logic w_rdy [0:NCONV];

    // Leading zero search stage.
    logic             r_lz_vld;
    logic             r_lz_neg;
    t_bcd             r_lz_bcd;
    logic [IDX_W-1:0] r_lz_idx;
    logic [IDX_W-1:0] n_lz_idx;
    logic             w_lz_rdy;

    // Character serializer and output register.
    logic             r_ser_busy;
    logic             r_ser_neg;
    t_bcd             r_ser_bcd;
    logic [IDX_W-1:0] r_ser_idx;
    logic             w_ser_rdy;
    logic             w_out_free;
    logic [3:0]       w_cur_dig;
    logic             r_o_valid;
    logic [7:0]       r_o_char;
    logic             r_o_last;

    // Backpressure: a stage takes a new beat when it is empty or its beat moves on.
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_ser_rdy  = !r_ser_busy || (w_out_free && !r_ser_neg && (r_ser_idx == '0));
    assign w_lz_rdy   = !r_lz_vld || w_ser_rdy;

    always_comb begin
        w_rdy[NCONV] = !r_vld[NCONV] || w_lz_rdy;
        for (int k = NCONV - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_stall = !w_rdy[0];

    // Input stage: split off the sign and form the unsigned magnitude.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_vld[0] <= i_valid;
        end
        if (w_rdy[0] && i_valid) begin
            r_neg[0] <= i_value[VALUE_BITS-1];
            r_bcd[0] <= '0;
            r_bin[0] <= i_value[VALUE_BITS-1] ? t_mag'(-i_value) : t_mag'(i_value);
        end
    end

    // Conversion stages: double dabble, ITERS_PER_STAGE iterations per stage.
    for (genvar s = 1; s <= NCONV; s++) begin : g_conv
        t_bcd n_bcd;
        t_mag n_bin;

        always_comb begin
            n_bcd = r_bcd[s-1];
            n_bin = r_bin[s-1];
            for (int it = 0; it < ITERS_PER_STAGE; it++) begin
                if ((s - 1) * ITERS_PER_STAGE + it < VALUE_BITS) begin
                    for (int d = 0; d < NUM_DIG; d++) begin
                        if (n_bcd[d*4 +: 4] >= 4'd5) begin
                            n_bcd[d*4 +: 4] = n_bcd[d*4 +: 4] + 4'd3;
                        end
                    end
                    n_bcd = {n_bcd[BCD_W-2:0], n_bin[VALUE_BITS-1]};
                    n_bin = {n_bin[VALUE_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_vld[s] <= r_vld[s-1];
            end
            if (w_rdy[s] && r_vld[s-1]) begin
                r_neg[s] <= r_neg[s-1];
                r_bcd[s] <= n_bcd;
                r_bin[s] <= n_bin;
            end
        end
    end

    // Find the most significant nonzero digit; zero prints one digit.
    always_comb begin
        n_lz_idx = '0;
        for (int d = 0; d < NUM_DIG; d++) begin
            if (r_bcd[NCONV][d*4 +: 4] != 4'd0) begin
                n_lz_idx = IDX_W'(d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lz_vld <= 1'b0;
        end else if (w_lz_rdy) begin
            r_lz_vld <= r_vld[NCONV];
        end
        if (w_lz_rdy && r_vld[NCONV]) begin
            r_lz_neg <= r_neg[NCONV];
            r_lz_bcd <= r_bcd[NCONV];
            r_lz_idx <= n_lz_idx;
        end
    end

    // Serializer: sign first, then digits from the top index down to zero.
    assign w_cur_dig = r_ser_bcd[{r_ser_idx, 2'b00} +: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_busy <= 1'b0;
            r_ser_neg  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_out_free) begin
                if (r_ser_busy) begin
                    r_o_valid <= 1'b1;
                    if (r_ser_neg) begin
                        r_o_char  <= CHAR_MINUS;
                        r_o_last  <= 1'b0;
                        r_ser_neg <= 1'b0;
                    end else begin
                        r_o_char <= CHAR_ZERO + {4'b0000, w_cur_dig};
                        r_o_last <= (r_ser_idx == '0);
                        if (r_ser_idx == '0) begin
                            // Go idle unless the next value loads below.
                            if (!r_lz_vld) begin
                                r_ser_busy <= 1'b0;
                            end
                        end else begin
                            r_ser_idx <= r_ser_idx - 1'b1;
                        end
                    end
                end else begin
                    r_o_valid <= 1'b0;
                end
            end
            // A new value loads as the previous text hands over its last character.
            if (w_ser_rdy && r_lz_vld) begin
                r_ser_busy <= 1'b1;
                r_ser_neg  <= r_lz_neg;
                r_ser_bcd  <= r_lz_bcd;
                r_ser_idx  <= r_lz_idx;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_text_char = r_o_char;
    assign o_last_char = r_o_last;

`ifndef SYNTHESIS
    // A text that is not finished continues on the very next cycle.
    a_no_gap_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_char) |=> o_valid)
        else $error("gap inside the characters of one value");

    // The minus sign is never the final character.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_text_char == CHAR_MINUS) |-> !o_last_char)
        else $error("minus sign flagged as last character");

    // The serializer only ever reads proper decimal digits.
    a_bcd_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ser_busy && !r_ser_neg) |-> (w_cur_dig <= 4'd9))
        else $error("conversion produced a digit above nine");

    // An accepted input beat is held in the input stage.
    a_input_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted input beat was dropped");
`endif

endmodule : signed_decimal_ascii_formatter_unit

`default_nettype wire
